// File: rtl/hmbs_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap sampler package
// Shared types and constants for the heightmap store and its interpolator.
// ----------------------------------------------------------------------------
package hmbs_pkg;

	// Height word, signed Q8.8.
	localparam int H_W = 16;
	// Fraction width and the value that stands for one whole step.
	localparam int FRAC_W = 8;
	localparam int FRAC_ONE = 256;
	// Configuration index and data widths.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	typedef logic signed [H_W-1:0] height_t;

	// Operation codes of an input item.
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_FILL   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

	// One request to the interpolation unit.
	typedef struct packed {
		logic               load;
		height_t            base;
		height_t            target;
		logic [FRAC_W-1:0]  frac;
	} interp_req_t;

endpackage

// File: rtl/hmbs_interp.sv
// ----------------------------------------------------------------------------
// Heightmap sampler interpolation unit
// Registers base and (target - base) * frac, then forms
// base + product / 256 with truncation toward zero in the next cycle.
// ----------------------------------------------------------------------------
module hmbs_interp import hmbs_pkg::*; (
	input  logic        clk,
	input  interp_req_t req,
	output height_t     result
);

	localparam int PROD_W = H_W + FRAC_W + 2;

	logic signed [H_W:0]      diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] adj;
	logic signed [PROD_W-1:0] quot;
	height_t                  base_q;

	// Difference and product; the fraction is unsigned.
	assign diff = {req.target[H_W-1], req.target} - {req.base[H_W-1], req.base};
	assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, req.frac}));

	always_ff @(posedge clk) begin
		if (req.load) begin
			base_q <= req.base;
			prod_q <= prod;
		end
	end

	// Bias negative products so the arithmetic shift truncates toward zero.
	assign adj  = prod_q + (prod_q[PROD_W-1] ? PROD_W'(FRAC_ONE - 1) : PROD_W'(0));
	assign quot = adj >>> FRAC_W;

	// The sum lies between the two operands, so 16 bits always hold it.
	assign result = base_q + H_W'(quot);

endmodule

// File: rtl/heightmap_store_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// Heightmap store with clamped bilinear sampling
// Row-major grid of Q8.8 heights in one synchronous memory. Serves vertex
// writes, bilinear samples and rectangle fills; exactly one result per item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  item      in         start & !busy             op, grid_x, grid_z, frac_x,
//                                                 frac_z, region_width,
//                                                 region_depth, height_in
//  result    out        done (one-cycle strobe)   height_out, status
//  config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// After reset the block clears the store, one entry a cycle, through all
// MAX_COLUMNS * MAX_ROWS entries with busy high; config writes are taken then.
// A write passes through the write state to its result; an unused op code
// answers from the idle state. A sample makes four reads through the single
// memory port and, interleaved with them, three interpolations through one
// shared multiplier. A fill makes one memory write a vertex of the clipped
// rectangle; an empty or fully outside fill answers from the idle state.
// The result strobe cannot be held off; busy alone paces the input side.
// ----------------------------------------------------------------------------
module heightmap_store_bilinear_sampler import hmbs_pkg::*; #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Item channel
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            op,
	input  logic [7:0]            grid_x,
	input  logic [7:0]            grid_z,
	input  logic [7:0]            frac_x,
	input  logic [7:0]            frac_z,
	input  logic [7:0]            region_width,
	input  logic [7:0]            region_depth,
	input  logic signed [15:0]    height_in,
	// Result channel
	output logic                  done,
	output logic signed [15:0]    height_out,
	output logic                  status,
	// Configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_COLUMNS);
	localparam int ZW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLUMNS + 1);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int PW    = ZW + CW;
	localparam logic [CW-1:0] COLS_RST = CW'(MAX_COLUMNS < 128 ? MAX_COLUMNS : 128);
	localparam logic [RW-1:0] ROWS_RST = RW'(MAX_ROWS < 128 ? MAX_ROWS : 128);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WRITE,
		S_FILL,
		S_SAMPLE
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  clr_q;
	logic [CW-1:0]  cols_q;
	logic [RW-1:0]  rows_q;
	logic [XW-1:0]  x_q;
	logic [XW-1:0]  x1_q;
	logic [XW-1:0]  xs_q;
	logic [ZW-1:0]  z_q;
	logic [ZW-1:0]  z1_q;
	logic [CW-1:0]  x_end_q;
	logic [RW-1:0]  z_end_q;
	logic [FRAC_W-1:0] fx_q;
	logic [FRAC_W-1:0] fz_q;
	height_t        hval_q;
	logic           wr_ok_q;
	logic           oob_q;
	logic [2:0]     phase_q;
	height_t        h0_q;
	height_t        i0_q;
	height_t        i1_q;
	logic           done_q;
	height_t        hout_q;
	logic           status_q;

	height_t        height_mem_q [DEPTH];
	height_t        rdata_q;
	logic           mem_we;
	height_t        mem_wdata;
	logic [AW-1:0]  mem_addr;
	logic [XW-1:0]  ax;
	logic [ZW-1:0]  az;
	logic [PW-1:0]  addr_full;

	interp_req_t    ireq;
	height_t        ires;

	// Accept-time decode.
	logic [8:0]     c9;
	logic [8:0]     r9;
	logic [8:0]     gx9;
	logic [8:0]     gz9;
	logic [8:0]     cm9;
	logic [8:0]     rm9;
	logic [8:0]     x0_c;
	logic [8:0]     x1_c;
	logic [8:0]     z0_c;
	logic [8:0]     z1_c;
	logic [8:0]     x_sum;
	logic [8:0]     z_sum;
	logic [8:0]     x_end_c;
	logic [8:0]     z_end_c;
	logic           in_grid;
	logic           fill_any;
	logic           fill_run;
	logic           fill_oob;
	logic [8:0]     cfg9;
	logic           fill_row_end;
	logic           fill_last;

	assign busy      = (state_q != S_IDLE);
	// An item offered in the idle state goes first, so a size change never
	// lands on the edge that takes an item.
	assign cfg_ready = (state_q == S_CLEAR) || ((state_q == S_IDLE) && !start);
	assign done       = done_q;
	assign height_out = hout_q;
	assign status     = status_q;

	// Neighbor clamping, bounds checks and fill clipping on the raw inputs.
	always_comb begin
		c9      = 9'(cols_q);
		r9      = 9'(rows_q);
		gx9     = {1'b0, grid_x};
		gz9     = {1'b0, grid_z};
		cm9     = c9 - 9'd1;
		rm9     = r9 - 9'd1;
		x0_c    = (gx9 < cm9) ? gx9 : cm9;
		x1_c    = ((gx9 + 9'd1) < cm9) ? (gx9 + 9'd1) : cm9;
		z0_c    = (gz9 < rm9) ? gz9 : rm9;
		z1_c    = ((gz9 + 9'd1) < rm9) ? (gz9 + 9'd1) : rm9;
		in_grid = (gx9 < c9) && (gz9 < r9);
		x_sum   = gx9 + {1'b0, region_width};
		z_sum   = gz9 + {1'b0, region_depth};
		x_end_c = (x_sum > c9) ? c9 : x_sum;
		z_end_c = (z_sum > r9) ? r9 : z_sum;
		fill_any = (region_width != 8'd0) && (region_depth != 8'd0);
		fill_run = fill_any && in_grid;
		fill_oob = fill_any && ((x_sum > c9) || (z_sum > r9));
		cfg9    = {1'b0, cfg_data};
	end

	// Fill loop position.
	assign fill_row_end = ((CW'(x_q) + CW'(1)) == x_end_q);
	assign fill_last    = fill_row_end && ((RW'(z_q) + RW'(1)) == z_end_q);

	// Memory port: clearing pass, single writes, fill writes, sample reads.
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = hval_q;
		ax        = x_q;
		az        = z_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			S_WRITE: begin
				mem_we = wr_ok_q;
			end
			S_FILL: begin
				mem_we = 1'b1;
			end
			S_SAMPLE: begin
				ax = phase_q[0] ? x1_q : x_q;
				az = phase_q[1] ? z1_q : z_q;
			end
			S_IDLE: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign addr_full = PW'(ax) + PW'(az) * PW'(cols_q);
	assign mem_addr  = (state_q == S_CLEAR) ? clr_q : AW'(addr_full);

	// Height store, one port, registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			height_mem_q[mem_addr] <= mem_wdata;
		end
		rdata_q <= height_mem_q[mem_addr];
	end

	// Interpolation requests: two along x from memory data, one along z.
	always_comb begin
		ireq.load   = (state_q == S_SAMPLE) &&
			((phase_q == 3'd2) || (phase_q == 3'd4) || (phase_q == 3'd6));
		ireq.base   = (phase_q == 3'd6) ? i0_q : h0_q;
		ireq.target = (phase_q == 3'd6) ? i1_q : rdata_q;
		ireq.frac   = (phase_q == 3'd6) ? fz_q : fx_q;
	end

	hmbs_interp u_interp (
		.clk    (clk),
		.req    (ireq),
		.result (ires)
	);

	// Configuration registers hold the clamped grid size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RST;
			rows_q <= ROWS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_COLS) begin
				if (cfg9 == 9'd0) begin
					cols_q <= CW'(1);
				end else if (cfg9 > 9'(MAX_COLUMNS)) begin
					cols_q <= CW'(MAX_COLUMNS);
				end else begin
					cols_q <= CW'(cfg9);
				end
			end else if (cfg_index == CFG_ROWS) begin
				if (cfg9 == 9'd0) begin
					rows_q <= RW'(1);
				end else if (cfg9 > 9'(MAX_ROWS)) begin
					rows_q <= RW'(MAX_ROWS);
				end else begin
					rows_q <= RW'(cfg9);
				end
			end
		end
	end

	// Sequencer with its datapath registers and the result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			x_q      <= '0;
			x1_q     <= '0;
			xs_q     <= '0;
			z_q      <= '0;
			z1_q     <= '0;
			x_end_q  <= '0;
			z_end_q  <= '0;
			fx_q     <= '0;
			fz_q     <= '0;
			hval_q   <= '0;
			wr_ok_q  <= 1'b0;
			oob_q    <= 1'b0;
			phase_q  <= '0;
			h0_q     <= '0;
			i0_q     <= '0;
			i1_q     <= '0;
			done_q   <= 1'b0;
			hout_q   <= '0;
			status_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						hval_q <= height_in;
						unique case (op_t'(op))
							OP_WRITE: begin
								x_q     <= XW'(grid_x);
								z_q     <= ZW'(grid_z);
								wr_ok_q <= in_grid;
								state_q <= S_WRITE;
							end
							OP_SAMPLE: begin
								x_q     <= XW'(x0_c);
								x1_q    <= XW'(x1_c);
								z_q     <= ZW'(z0_c);
								z1_q    <= ZW'(z1_c);
								fx_q    <= frac_x;
								fz_q    <= frac_z;
								phase_q <= '0;
								state_q <= S_SAMPLE;
							end
							OP_FILL: begin
								oob_q <= fill_oob;
								if (fill_run) begin
									x_q     <= XW'(grid_x);
									xs_q    <= XW'(grid_x);
									z_q     <= ZW'(grid_z);
									x_end_q <= CW'(x_end_c);
									z_end_q <= RW'(z_end_c);
									state_q <= S_FILL;
								end else begin
									done_q   <= 1'b1;
									hout_q   <= '0;
									status_q <= fill_oob;
								end
							end
							OP_NOP: begin
								done_q   <= 1'b1;
								hout_q   <= '0;
								status_q <= 1'b0;
							end
							default: begin
								done_q <= 1'b0;
							end
						endcase
					end
				end
				S_WRITE: begin
					done_q   <= 1'b1;
					hout_q   <= '0;
					status_q <= !wr_ok_q;
					state_q  <= S_IDLE;
				end
				S_FILL: begin
					if (fill_last) begin
						done_q   <= 1'b1;
						hout_q   <= '0;
						status_q <= oob_q;
						state_q  <= S_IDLE;
					end else if (fill_row_end) begin
						x_q <= xs_q;
						z_q <= z_q + ZW'(1);
					end else begin
						x_q <= x_q + XW'(1);
					end
				end
				S_SAMPLE: begin
					phase_q <= phase_q + 3'd1;
					unique case (phase_q)
						3'd1: h0_q <= rdata_q;
						3'd3: begin
							i0_q <= ires;
							h0_q <= rdata_q;
						end
						3'd5: i1_q <= ires;
						3'd7: begin
							done_q   <= 1'b1;
							hout_q   <= ires;
							status_q <= 1'b0;
							state_q  <= S_IDLE;
						end
						default: begin
							h0_q <= h0_q;
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The store is written only by the clearing pass, a write or a fill.
	a_we_source: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_WRITE || state_q == S_FILL))
		else $error("store written outside a writing state");

	// An accepted item either keeps the block busy or has its result out.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither in work nor answered");

	// A fill never walks outside the clipped grid.
	a_fill_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> ((CW'(x_q) < cols_q) && (RW'(z_q) < rows_q)))
		else $error("fill position outside the grid");

	// A sample result never reports a skipped write.
	a_sample_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(state_q == S_SAMPLE)) |-> !status)
		else $error("sample result flagged as skipped write");

endmodule
